>>> src/acsi_command_frame_receiver_macros.svh
// Assertion macros for the checker file of the command frame receiver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ACSI_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define ACSI_COMMAND_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acfr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acfr: next-cycle check failed");

`endif

>>> src/acfr_pkg.sv
`timescale 1ns / 1ps

package acfr_pkg;

  // Bus event codes carried by the input func field. Code 3 is handled as an error.
  typedef enum logic [1:0] {
    FUNC_FIRST = 2'd0,
    FUNC_NEXT  = 2'd1,
    FUNC_ERROR = 2'd2
  } func_t;

  localparam int FRAME_BYTES = 14;
  localparam int FRAME_WORDS = 7;
  localparam int WORD_IDX_W  = 3;
  localparam int COUNT_W     = 4;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 3'd6;

  localparam logic [COUNT_W-1:0] LEN_BASE      = 4'd6;
  localparam logic [COUNT_W-1:0] LEN_ICD_SHORT = 4'd7;
  localparam logic [COUNT_W-1:0] LEN_ICD_MID   = 4'd11;
  localparam logic [COUNT_W-1:0] LEN_ICD_LONG  = 4'd13;
  localparam logic [4:0]         ICD_OPCODE    = 5'h1f;

  typedef struct packed {
    logic [FRAME_WORDS-1:0][15:0] words;
    logic [2:0]                   device_id;
    logic [COUNT_W-1:0]           length;
  } frame_t;

  typedef struct packed {
    logic   load;
    frame_t frame;
  } load_req_t;

  // Command length from the first two bytes; extended commands use byte 1 bits 7:5.
  function automatic logic [COUNT_W-1:0] decode_length(input logic [7:0] b0,
                                                       input logic [7:0] b1);
    logic [2:0] ext;
    ext = b1[7:5];
    if (b0[4:0] != ICD_OPCODE) begin
      return LEN_BASE;
    end
    case (ext) inside
      3'd1, 3'd2: return LEN_ICD_MID;
      3'd5:       return LEN_ICD_LONG;
      default:    return LEN_ICD_SHORT;
    endcase
  endfunction

endpackage

>>> src/acsi_command_frame_receiver.sv
`timescale 1ns / 1ps
// Command frame receiver for a disk bus target.
// Input channel (in_valid / in_stall, in_func, in_bus_byte): one bus event per
// transaction, either a first command byte, a following byte or a bus error.
// Output channel (out_valid / out_stall): each completed frame leaves as seven
// transactions of one 16-bit word each, with index, device id, frame length and
// a flag on the seventh word.
// Configuration: cfg_write_en with cfg_write_data loads the enabled id mask.
// The first word is offered in the cycle after the byte that completes the frame
// is accepted. One input transaction per cycle; one output word per cycle while
// out_stall is low, the word emitter stepping through the seven words of a frame.
// Only a completing byte that arrives while the emitter still holds an earlier
// frame (other than on its final word leaving) is stalled; all other events are
// taken at once. Reset is synchronous and active low: it empties the emitter,
// sets the mask to device 0 only, clears the command buffer to zero and returns
// the assembler to idle. While out_stall is high the current word is held.
module acsi_command_frame_receiver import acfr_pkg::*; #(
  parameter int BUFFER_BYTES = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_bus_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_frame_word,
  output logic [WORD_IDX_W-1:0] out_word_index,
  output logic [2:0]            out_device_id,
  output logic [COUNT_W-1:0]    out_frame_length,
  output logic                  out_last_word,
  input  logic                  cfg_write_en,
  input  logic [7:0]            cfg_write_data
);

  load_req_t load_req;
  logic      can_load;

  // Assembler: holds the frame state and the command buffer, and hands a full
  // snapshot of the frame to the emitter when the expected byte count is reached.
  acfr_assembler #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_assembler (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_bus_byte   (in_bus_byte),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .can_load      (can_load),
    .load_req      (load_req)
  );

  // Emitter: the result register, stepping through the seven words of a frame.
  acfr_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_req        (load_req),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_word  (out_frame_word),
    .out_word_index  (out_word_index),
    .out_device_id   (out_device_id),
    .out_frame_length(out_frame_length),
    .out_last_word   (out_last_word)
  );

endmodule

>>> src/acfr_assembler.sv
`timescale 1ns / 1ps

module acfr_assembler import acfr_pkg::*; #(
  parameter int BUFFER_BYTES = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_bus_byte,
  input  logic            cfg_write_en,
  input  logic [7:0]      cfg_write_data,
  input  logic            can_load,
  output load_req_t       load_req
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);

  logic [7:0]                   mask_r;
  logic                         collecting_r, collecting_nxt;
  logic [COUNT_W-1:0]           cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]           exp_r, exp_nxt;
  logic [BUFFER_BYTES-1:0][7:0] cmd_bytes_r, cmd_bytes_nxt;

  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] exp_new;
  logic               completes;
  logic               accept;

  assign cnt_inc   = cnt_r + COUNT_W'(1);
  assign exp_new   = (cnt_inc == COUNT_W'(2)) ? decode_length(cmd_bytes_r[0], in_bus_byte)
                                              : exp_r;
  assign completes = (in_func == FUNC_NEXT) && collecting_r && (cnt_inc >= exp_new);
  assign in_stall  = completes && !can_load;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd_bytes_nxt  = cmd_bytes_r;
    collecting_nxt = collecting_r;
    cnt_nxt        = cnt_r;
    exp_nxt        = exp_r;
    case (func_t'(in_func))
      FUNC_FIRST: begin
        cmd_bytes_nxt[0] = in_bus_byte;
        if (mask_r[in_bus_byte[7:5]]) begin
          collecting_nxt = 1'b1;
          cnt_nxt        = COUNT_W'(1);
          exp_nxt        = LEN_BASE;
        end else begin
          collecting_nxt = 1'b0;
        end
      end
      FUNC_NEXT: begin
        if (collecting_r) begin
          if ({1'b0, cnt_r} < (COUNT_W + 1)'(BUFFER_BYTES)) begin
            cmd_bytes_nxt[cnt_r[IDX_W-1:0]] = in_bus_byte;
          end
          cnt_nxt = cnt_inc;
          exp_nxt = exp_new;
          if (completes) begin
            collecting_nxt = 1'b0;
          end
        end
      end
      default: begin
        collecting_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    load_req.load = accept && completes;
    for (int k = 0; k < FRAME_WORDS; k++) begin
      load_req.frame.words[k] = {cmd_bytes_nxt[2*k], cmd_bytes_nxt[2*k+1]};
    end
    load_req.frame.device_id = cmd_bytes_r[0][7:5];
    load_req.frame.length    = cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= 8'h01;
      collecting_r <= 1'b0;
      cnt_r        <= '0;
      exp_r        <= LEN_BASE;
      cmd_bytes_r  <= '0;
    end else begin
      if (cfg_write_en) begin
        mask_r <= cfg_write_data;
      end
      if (accept) begin
        collecting_r <= collecting_nxt;
        cnt_r        <= cnt_nxt;
        exp_r        <= exp_nxt;
        cmd_bytes_r  <= cmd_bytes_nxt;
      end
    end
  end

endmodule

>>> src/acfr_emitter.sv
`timescale 1ns / 1ps

module acfr_emitter import acfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  load_req_t             load_req,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_frame_word,
  output logic [WORD_IDX_W-1:0] out_word_index,
  output logic [2:0]            out_device_id,
  output logic [COUNT_W-1:0]    out_frame_length,
  output logic                  out_last_word
);

  logic                  pending_r;
  logic [WORD_IDX_W-1:0] idx_r;
  frame_t                frame_r;
  logic                  last;

  assign last     = (idx_r == LAST_WORD_IDX);
  // A new frame may be loaded while the final word of the current one leaves.
  assign can_load = !pending_r || (last && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      idx_r     <= '0;
    end else if (load_req.load) begin
      pending_r <= 1'b1;
      idx_r     <= '0;
    end else if (pending_r && !out_stall) begin
      if (last) begin
        pending_r <= 1'b0;
        idx_r     <= '0;
      end else begin
        idx_r <= idx_r + WORD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_req.load) begin
      frame_r <= load_req.frame;
    end
  end

  assign out_valid        = pending_r;
  assign out_frame_word   = frame_r.words[idx_r];
  assign out_word_index   = idx_r;
  assign out_device_id    = frame_r.device_id;
  assign out_frame_length = frame_r.length;
  assign out_last_word    = last;

endmodule

>>> src/acfr_checker.sv
`timescale 1ns / 1ps
`include "acsi_command_frame_receiver_macros.svh"

module acfr_checker import acfr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [15:0]           out_frame_word,
  input logic [WORD_IDX_W-1:0] out_word_index,
  input logic [COUNT_W-1:0]    out_frame_length,
  input logic                  out_last_word
);

  // A stalled word must stay offered and unchanged.
  `ACFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_frame_word) && $stable(out_word_index))

  // The flag marks exactly the seventh word.
  `ACFR_ASSERT_SAME(a_last_flag, out_valid,
                    out_last_word == (out_word_index == LAST_WORD_IDX))

  // Words of one frame leave in order without gaps.
  `ACFR_ASSERT_NEXT(a_word_seq, out_valid && !out_stall && !out_last_word,
                    out_valid && (out_word_index == $past(out_word_index) + WORD_IDX_W'(1)))

  // Frame lengths lie between the base and the longest extended command.
  `ACFR_ASSERT_SAME(a_length_range, out_valid,
                    (out_frame_length >= LEN_BASE) && (out_frame_length <= LEN_ICD_LONG))

endmodule

bind acsi_command_frame_receiver acfr_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_frame_word  (out_frame_word),
  .out_word_index  (out_word_index),
  .out_frame_length(out_frame_length),
  .out_last_word   (out_last_word)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the command frame receiver. A behavioural model of the
// frame assembler runs alongside the block and queues the seven words that each
// completed frame must produce; every word transaction that leaves the block is
// compared, field by field, with the oldest queued word.
module tb;
  import acfr_pkg::*;

  // The block handles the unused func code like a bus error.
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  // Cycles without any transaction on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;

  // Quiet cycles allowed after the last expected word, before a mask write and at
  // the end, so that anything still inside the block has time to come out.
  localparam int SETTLE_CYCLES = 16;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  // One word of an emitted frame, as the output channel carries it.
  typedef struct packed {
    logic [15:0]           word;
    logic [WORD_IDX_W-1:0] index;
    logic [2:0]            device_id;
    logic [COUNT_W-1:0]    length;
    logic                  last;
  } cmd_word_t;

  // One row of the directed sequence. frame_len is the length of the frame that
  // this bus event completes, or zero where the event completes nothing.
  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         data;
    logic [COUNT_W-1:0] frame_len;
  } bus_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_func;
  logic [7:0]            in_bus_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_frame_word;
  logic [WORD_IDX_W-1:0] out_word_index;
  logic [2:0]            out_device_id;
  logic [COUNT_W-1:0]    out_frame_length;
  logic                  out_last_word;
  logic                  cfg_write_en;
  logic [7:0]            cfg_write_data;

  // Words still owed by the block, oldest first.
  cmd_word_t words_due[$];

  int      fail_count = 0;
  // Bus events that the block acted on; following bytes while idle are not counted.
  int      live_events = 0;
  idling_t idling = IDLE_NONE;

  // Model copy of the register and of the assembler state.
  logic [7:0]         id_mask;
  logic               assembling;
  logic [COUNT_W-1:0] bytes_seen;
  logic [COUNT_W-1:0] target_len;
  logic [7:0]         cmd_buf [FRAME_BYTES];

  acsi_command_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_bus_byte      (in_bus_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_word   (out_frame_word),
    .out_word_index   (out_word_index),
    .out_device_id    (out_device_id),
    .out_frame_length (out_frame_length),
    .out_last_word    (out_last_word),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Frame length from the first two command bytes. Ordinary commands are six bytes
  // long; an extended command (opcode field all ones) takes its length from the top
  // three bits of the second byte.
  function automatic logic [COUNT_W-1:0] command_length(input logic [7:0] b0,
                                                        input logic [7:0] b1);
    if (b0[4:0] != ICD_OPCODE) begin
      return LEN_BASE;
    end
    case (b1[7:5])
      3'd1, 3'd2: return LEN_ICD_MID;
      3'd5:       return LEN_ICD_LONG;
      default:    return LEN_ICD_SHORT;
    endcase
  endfunction

  // Applies one accepted bus event to the model. When the event completes a frame,
  // the seven words are queued and done_len returns the frame length.
  function automatic void apply_bus_event(input logic [1:0] func, input logic [7:0] data,
                                          output logic [COUNT_W-1:0] done_len);
    cmd_word_t w;
    done_len = '0;
    if (func == FUNC_FIRST) begin
      // A first byte always lands in byte 0, even when its device is not served,
      // and it drops any frame that was being assembled.
      live_events++;
      cmd_buf[0] = data;
      if (id_mask[data[7:5]]) begin
        assembling = 1'b1;
        bytes_seen = 4'd1;
        target_len = LEN_BASE;
      end else begin
        assembling = 1'b0;
      end
    end else if (func == FUNC_NEXT) begin
      if (assembling) begin
        live_events++;
        if (bytes_seen < FRAME_BYTES) begin
          cmd_buf[bytes_seen] = data;
        end
        bytes_seen = bytes_seen + 1'b1;
        if (bytes_seen == 4'd2) begin
          target_len = command_length(cmd_buf[0], cmd_buf[1]);
        end
        if (bytes_seen >= target_len) begin
          // The whole buffer goes out, including bytes left over from earlier frames.
          assembling = 1'b0;
          done_len = bytes_seen;
          for (int k = 0; k < FRAME_WORDS; k++) begin
            w.word      = {cmd_buf[2*k], cmd_buf[2*k+1]};
            w.index     = WORD_IDX_W'(k);
            w.device_id = cmd_buf[0][7:5];
            w.length    = bytes_seen;
            w.last      = (k == FRAME_WORDS - 1);
            words_due.push_back(w);
          end
        end
      end
    end else begin
      // A bus error, or the unused code, abandons the frame and keeps the buffer.
      live_events++;
      assembling = 1'b0;
    end
  endfunction

  function automatic void check_field(input string field, input logic [15:0] expected,
                                      input logic [15:0] actual);
    if (actual !== expected) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expected, actual);
    end
  endfunction

  // Offers one bus event, with a random number of idle cycles in front of it
  // according to the current idling phase, and waits for the transaction to be
  // accepted. valid stays high from one event to the next when there is no gap.
  task automatic send_event(input logic [1:0] func, input logic [7:0] data,
                            output logic [COUNT_W-1:0] done_len);
    int gap_pct;
    gap_pct = (idling == IDLE_SENDER) ? 49 : (idling == IDLE_BOTH) ? 10 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_bus_byte <= data;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    apply_bus_event(func, data, done_len);
  endtask

  // Writes the id mask once the block has delivered every word it owes and has had
  // time to settle. The caller has already lowered in_valid.
  task automatic load_id_mask(input logic [7:0] mask);
    while (words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mask;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    id_mask = mask;
  endtask

  // Random traffic, mostly well-formed frames for a served device with random
  // content. At least half of them are extended commands, so every extended length can turn up.
  // The rest is noise: stray events of any code, and frames broken by an error or
  // restarted by a new first byte.
  task automatic random_traffic(input int n_events);
    logic [COUNT_W-1:0] done_len;
    logic [2:0]         id;
    logic [4:0]         opcode;
    int                 guard;
    int                 stop_at;
    stop_at = live_events + n_events;
    while (live_events < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        id = 3'($urandom_range(0, 7));
        if (id_mask != 8'h00) begin
          while (!id_mask[id]) begin
            id = 3'($urandom_range(0, 7));
          end
        end
        opcode = ($urandom_range(0, 1) != 0) ? ICD_OPCODE : 5'($urandom_range(0, 31));
        send_event(FUNC_FIRST, {id, opcode}, done_len);
        guard = 0;
        while (assembling && guard < FRAME_BYTES) begin
          guard++;
          case ($urandom_range(0, 49))
            0:       send_event(FUNC_ERROR, 8'($urandom), done_len);
            1:       send_event(FUNC_RESERVED, 8'($urandom), done_len);
            2:       send_event(FUNC_FIRST, 8'($urandom), done_len);
            default: send_event(FUNC_NEXT, 8'($urandom), done_len);
          endcase
        end
      end else begin
        send_event(2'($urandom_range(0, 3)), 8'($urandom), done_len);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Output side: checks every accepted word transaction against the oldest queued
  // word and draws the receiver stall for the next cycle.
  initial begin : word_monitor
    cmd_word_t exp_w;
    int        stall_pct;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          fail_count++;
          $display("%0t: word %0h at index %0d arrived with none expected", $time,
                   out_frame_word, out_word_index);
        end else begin
          exp_w = words_due.pop_front();
          check_field("frame_word", exp_w.word, out_frame_word);
          check_field("word_index", exp_w.index, out_word_index);
          check_field("device_id", exp_w.device_id, out_device_id);
          check_field("frame_length", exp_w.length, out_frame_length);
          check_field("last_word", exp_w.last, out_last_word);
        end
      end
      stall_pct = (idling == IDLE_RECEIVER) ? 49 : (idling == IDLE_BOTH) ? 10 : 0;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    bus_row_t           rows [24];
    logic [COUNT_W-1:0] done_len;

    // Directed sequence under the reset mask, which serves device 0 only.
    rows = '{
      '{FUNC_NEXT,     8'hFF, 4'd0},  // following byte while idle: ignored
      '{FUNC_FIRST,    8'hFF, 4'd0},  // device 7 is not served
      '{FUNC_FIRST,    8'h00, 4'd0},  // device 0 opens a frame
      '{FUNC_NEXT,     8'hFF, 4'd0},
      '{FUNC_ERROR,    8'h00, 4'd0},  // bus error drops it
      '{FUNC_NEXT,     8'h12, 4'd0},  // ignored after the error
      '{FUNC_FIRST,    8'h1F, 4'd0},  // extended command
      '{FUNC_NEXT,     8'h00, 4'd0},  // short extended length
      '{FUNC_FIRST,    8'h1F, 4'd0},  // restart in the middle of a frame
      '{FUNC_NEXT,     8'h3F, 4'd0},  // middle extended length
      '{FUNC_RESERVED, 8'hA5, 4'd0},  // unused code aborts like an error
      '{FUNC_FIRST,    8'h08, 4'd0},  // ordinary six-byte command
      '{FUNC_NEXT,     8'hFF, 4'd0},
      '{FUNC_NEXT,     8'h00, 4'd0},
      '{FUNC_NEXT,     8'h81, 4'd0},
      '{FUNC_NEXT,     8'h7E, 4'd0},
      '{FUNC_NEXT,     8'hC3, 4'd6},  // six bytes, the remainder still zero
      '{FUNC_FIRST,    8'h1F, 4'd0},
      '{FUNC_NEXT,     8'hE0, 4'd0},  // top bits 7 fall back to the short length
      '{FUNC_NEXT,     8'h11, 4'd0},
      '{FUNC_NEXT,     8'h22, 4'd0},
      '{FUNC_NEXT,     8'h33, 4'd0},
      '{FUNC_NEXT,     8'h44, 4'd0},
      '{FUNC_NEXT,     8'h55, 4'd7}
    };

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_FIRST;
    in_bus_byte    <= 8'h00;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 8'h00;
    id_mask    = 8'h01;
    assembling = 1'b0;
    bytes_seen = '0;
    target_len = LEN_BASE;
    foreach (cmd_buf[i]) begin
      cmd_buf[i] = 8'h00;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_event(rows[i].func, rows[i].data, done_len);
      if (done_len != rows[i].frame_len) begin
        fail_count++;
        $display("%0t: row %0d frame length expected %0d, got %0d", $time, i,
                 rows[i].frame_len, done_len);
      end
    end
    in_valid <= 1'b0;

    // Random phases over several masks, the extremes among them, and every idling
    // pattern. With no device served no frame can open, so that phase is short.
    load_id_mask(8'hFF);
    idling = IDLE_NONE;
    random_traffic(80);
    load_id_mask(8'h00);
    idling = IDLE_SENDER;
    random_traffic(20);
    load_id_mask(8'($urandom_range(1, 254)));
    idling = IDLE_RECEIVER;
    random_traffic(80);
    load_id_mask(8'h80);
    idling = IDLE_BOTH;
    random_traffic(60);
    load_id_mask(8'($urandom_range(1, 255)));
    idling = IDLE_SENDER;
    random_traffic(60);

    // Drain: every owed word must arrive, and nothing more may follow.
    while (words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
